// ===== hdl/psc_pkg.sv =====
`default_nettype none

package psc_pkg;

    // result classes
    typedef enum logic [1:0] {
        CLASS_UNIQUE    = 2'd0,
        CLASS_DUPLICATE = 2'd1,
        CLASS_INVALID   = 2'd2
    } t_class;

    // field widths
    localparam int LEN_W     = 13;
    localparam int SEQ_W     = 32;
    localparam int CFG_W     = 17;
    localparam int CNT_W     = 64;
    localparam int SAT_LEN_W = 17;

    // sequence space and configuration defaults
    localparam int SEQ_SPACE_DEF = 65536;
    localparam logic [CFG_W-1:0] EXPECTED_RST = 17'd65536;

    // receive buffer size; longer lengths saturate to it
    localparam logic [SAT_LEN_W-1:0] MAX_PACKET_BYTES = 17'd4096;
    // a packet needs four bytes to carry its sequence number
    localparam logic [SAT_LEN_W-1:0] MIN_PACKET_BYTES = 17'd4;

    // seen bitmap organisation: one memory row holds this many bits
    localparam int ROW_BITS = 32;
    localparam int BIT_W    = 5;

endpackage

`default_nettype wire

// ===== hdl/psc_ram.sv =====
`default_nettype none

module psc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/packet_sequence_checker.sv =====
// Packet sequence checker: classifies each received packet as unique,
// duplicate or invalid from its length and its 32-bit sequence number and
// reports the class together with five running 64-bit totals (packets,
// bytes, unique, duplicate, invalid) that wrap. One packet is accepted per
// clock cycle with no bubbles unless the clearing sweep or a stalled result
// holds the input back; the bitmap row is read at the accepting edge
// together with the input register, and the classification lands in the result
// register when the input stage moves on. The bitmap lives in a single-port-write,
// registered-read memory of ceil(SEQ_SPACE/32) rows of 32 bits and is updated by
// read-modify-write, with the row written by the packet ahead forwarded to
// the packet behind it. After reset the block sweeps the bitmap clear, one
// row per cycle, and holds the input stalled meanwhile; configuration writes
// are taken at any time. expected_count is saturated to SEQ_SPACE, lengths
// to 4096 bytes.
`default_nettype none

module packet_sequence_checker #(
    parameter int SEQ_SPACE = psc_pkg::SEQ_SPACE_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [psc_pkg::CFG_W-1:0]   i_cfg_wr_data,
    // input beats
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [psc_pkg::LEN_W-1:0]   i_packet_length,
    input  wire logic [psc_pkg::SEQ_W-1:0]   i_sequence_number,
    // result beats
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [1:0]                       o_packet_class,
    output logic [psc_pkg::CNT_W-1:0]        o_packets_total,
    output logic [psc_pkg::CNT_W-1:0]        o_bytes_total,
    output logic [psc_pkg::CNT_W-1:0]        o_unique_total,
    output logic [psc_pkg::CNT_W-1:0]        o_duplicate_total,
    output logic [psc_pkg::CNT_W-1:0]        o_invalid_total
);

    localparam int ROW_BITS = psc_pkg::ROW_BITS;
    localparam int BIT_W    = psc_pkg::BIT_W;
    localparam int ROWS     = (SEQ_SPACE + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W    = psc_pkg::CNT_W;
    localparam int SEQ_W    = psc_pkg::SEQ_W;
    localparam int CFG_W    = psc_pkg::CFG_W;
    localparam int LEN_W    = psc_pkg::LEN_W;
    localparam int SAT_W    = psc_pkg::SAT_LEN_W;

    // sequence limit from the bitmap size, one bit wider than the sequence
    localparam logic [SEQ_W:0]    SEQ_LIMIT = (SEQ_W + 1)'(SEQ_SPACE);
    localparam logic [ROW_AW-1:0] LAST_ROW  = ROW_AW'(ROWS - 1);

    // ---------------------------------------------------------------
    // configuration: expected count, used saturated against SEQ_SPACE
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] r_expected;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= psc_pkg::EXPECTED_RST;
        end else if (i_cfg_wr_en) begin
            r_expected <= i_cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------
    // clearing sweep over the bitmap after reset
    // ---------------------------------------------------------------
    logic              r_clr_active;
    logic [ROW_AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + ROW_AW'(1);
            if (r_clr_addr == LAST_ROW) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_adv;
    logic in_accept;

    // the stage moves on when the result register is empty or being drained
    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_clr_active || (r_s1_valid && !s1_adv);
    assign in_accept  = i_in_valid && !o_in_stall;

    // ---------------------------------------------------------------
    // input stage: packet fields, bitmap row read issued on acceptance
    // ---------------------------------------------------------------
    logic [LEN_W-1:0] r_s1_len;
    logic [SEQ_W-1:0] r_s1_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_len <= i_packet_length;
            r_s1_seq <= i_sequence_number;
        end
    end

    // ---------------------------------------------------------------
    // classification
    // ---------------------------------------------------------------
    logic [SAT_W-1:0]    len_ext;
    logic [SAT_W-1:0]    len_sat;
    logic                pkt_short;
    logic                out_of_range;
    logic                pkt_invalid;
    logic [ROW_AW-1:0]   s1_row;
    logic [BIT_W-1:0]    s1_bit;
    logic [ROW_BITS-1:0] ram_rdata;
    logic [ROW_BITS-1:0] row_view;
    logic [ROW_BITS-1:0] row_new;
    logic                bit_seen;
    logic                s1_unique;
    logic                s1_wr;
    psc_pkg::t_class     s1_class;

    // forwarding of the row written by the beat ahead, at the edge on which
    // this beat's read was taken
    logic                r_fwd_valid;
    logic [ROW_AW-1:0]   r_fwd_row;
    logic [ROW_BITS-1:0] r_fwd_data;

    assign len_ext = SAT_W'(r_s1_len);
    assign len_sat = (len_ext > psc_pkg::MAX_PACKET_BYTES) ?
                     psc_pkg::MAX_PACKET_BYTES : len_ext;

    assign pkt_short    = len_sat < psc_pkg::MIN_PACKET_BYTES;
    assign out_of_range = ({1'b0, r_s1_seq} >= (SEQ_W + 1)'(r_expected)) ||
                          ({1'b0, r_s1_seq} >= SEQ_LIMIT);
    assign pkt_invalid  = pkt_short || out_of_range;

    assign s1_row = r_s1_seq[ROW_AW+BIT_W-1:BIT_W];
    assign s1_bit = r_s1_seq[BIT_W-1:0];

    assign row_view  = (r_fwd_valid && (r_fwd_row == s1_row)) ? r_fwd_data : ram_rdata;
    assign bit_seen  = row_view[s1_bit];
    assign row_new   = row_view | (ROW_BITS'(1) << s1_bit);
    assign s1_unique = !pkt_invalid && !bit_seen;
    assign s1_wr     = s1_adv && s1_unique;

    always_comb begin
        if (pkt_invalid) begin
            s1_class = psc_pkg::CLASS_INVALID;
        end else if (bit_seen) begin
            s1_class = psc_pkg::CLASS_DUPLICATE;
        end else begin
            s1_class = psc_pkg::CLASS_UNIQUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (in_accept) begin
            r_fwd_valid <= s1_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_fwd_row  <= s1_row;
            r_fwd_data <= row_new;
        end
    end

    // ---------------------------------------------------------------
    // seen bitmap memory
    // ---------------------------------------------------------------
    logic                ram_we;
    logic [ROW_AW-1:0]   ram_waddr;
    logic [ROW_BITS-1:0] ram_wdata;

    assign ram_we    = r_clr_active || s1_wr;
    assign ram_waddr = r_clr_active ? r_clr_addr : s1_row;
    assign ram_wdata = r_clr_active ? '0 : row_new;

    psc_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS),
        .AW    (ROW_AW)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (in_accept),
        .i_rd_addr (i_sequence_number[ROW_AW+BIT_W-1:BIT_W]),
        .o_rd_data (ram_rdata)
    );

    // ---------------------------------------------------------------
    // result register; the totals it holds are the running counters
    // ---------------------------------------------------------------
    logic [1:0]       r_class;
    logic [CNT_W-1:0] r_packets;
    logic [CNT_W-1:0] r_bytes;
    logic [CNT_W-1:0] r_unique;
    logic [CNT_W-1:0] r_duplicate;
    logic [CNT_W-1:0] r_invalid;
    logic [CNT_W-1:0] n_packets;
    logic [CNT_W-1:0] n_bytes;
    logic [CNT_W-1:0] n_unique;
    logic [CNT_W-1:0] n_duplicate;
    logic [CNT_W-1:0] n_invalid;

    assign n_packets   = r_packets + CNT_W'(1);
    assign n_bytes     = r_bytes + CNT_W'(len_sat);
    assign n_unique    = r_unique + CNT_W'(s1_class == psc_pkg::CLASS_UNIQUE);
    assign n_duplicate = r_duplicate + CNT_W'(s1_class == psc_pkg::CLASS_DUPLICATE);
    assign n_invalid   = r_invalid + CNT_W'(s1_class == psc_pkg::CLASS_INVALID);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_packets   <= '0;
            r_bytes     <= '0;
            r_unique    <= '0;
            r_duplicate <= '0;
            r_invalid   <= '0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
            r_packets   <= n_packets;
            r_bytes     <= n_bytes;
            r_unique    <= n_unique;
            r_duplicate <= n_duplicate;
            r_invalid   <= n_invalid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_class <= s1_class;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_packet_class    = r_class;
    assign o_packets_total   = r_packets;
    assign o_bytes_total     = r_bytes;
    assign o_unique_total    = r_unique;
    assign o_duplicate_total = r_duplicate;
    assign o_invalid_total   = r_invalid;

endmodule

`default_nettype wire

// ===== hdl/psc_checker.sv =====
`default_nettype none

module psc_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [1:0]                  o_packet_class,
    input wire logic [psc_pkg::CNT_W-1:0]   o_packets_total,
    input wire logic [psc_pkg::CNT_W-1:0]   o_unique_total,
    input wire logic [psc_pkg::CNT_W-1:0]   o_duplicate_total,
    input wire logic [psc_pkg::CNT_W-1:0]   o_invalid_total
);

    localparam int CNT_W = psc_pkg::CNT_W;

    // every packet lands in exactly one class total
    a_totals_add_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_packets_total == CNT_W'(o_unique_total + o_duplicate_total + o_invalid_total))
    else $error("class totals do not add up to packet total");

    // a new result bumps the total of its own class by one
    a_unique_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$stable(o_packets_total) && o_packet_class == psc_pkg::CLASS_UNIQUE) |->
        (o_unique_total == CNT_W'($past(o_unique_total) + CNT_W'(1))))
    else $error("unique total did not step with a unique result");

    a_duplicate_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$stable(o_packets_total) && o_packet_class == psc_pkg::CLASS_DUPLICATE) |->
        (o_duplicate_total == CNT_W'($past(o_duplicate_total) + CNT_W'(1))))
    else $error("duplicate total did not step with a duplicate result");

    a_invalid_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$stable(o_packets_total) && o_packet_class == psc_pkg::CLASS_INVALID) |->
        (o_invalid_total == CNT_W'($past(o_invalid_total) + CNT_W'(1))))
    else $error("invalid total did not step with an invalid result");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_packets_total)))
    else $error("stalled result beat changed");

endmodule

bind packet_sequence_checker psc_checker u_psc_checker (.*);

`default_nettype wire
